FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define MAHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked check that also holds through reset
`define MAHP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/mahp_pkg.sv
// types, codes and lookup tables of the mpeg audio header parser
package mahp_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [2:0] SYNC_BITS     = 3'b111;
    localparam logic [3:0] BRI_BAD       = 4'hF;
    localparam int         DIV_STEPS     = 12;
    localparam int         CNT_W         = $clog2(DIV_STEPS);
    localparam int         LEN_W         = 12;
    localparam int         RATE_W        = 16;
    localparam int         SAMP_W        = 11;
    localparam int         KBPS_W        = 9;
    localparam int         SCALED_W      = 18;
    localparam int         PROD_W        = SCALED_W + KBPS_W;
    localparam int         QDEPTH        = 4;
    localparam int         QPTR_W        = $clog2(QDEPTH);

    // version codes
    localparam logic [1:0] VER_25  = 2'd0;
    localparam logic [1:0] VER_RES = 2'd1;
    localparam logic [1:0] VER_2   = 2'd2;
    localparam logic [1:0] VER_1   = 2'd3;

    // layer codes
    localparam logic [1:0] LAYER_RES = 2'd0;
    localparam logic [1:0] LAYER_3   = 2'd1;
    localparam logic [1:0] LAYER_2   = 2'd2;
    localparam logic [1:0] LAYER_1   = 2'd3;

    // sample-rate index codes
    localparam logic [1:0] SRI_0   = 2'd0;
    localparam logic [1:0] SRI_1   = 2'd1;
    localparam logic [1:0] SRI_2   = 2'd2;
    localparam logic [1:0] SRI_RES = 2'd3;

    // one request handed from the front to the back
    typedef struct packed {
        logic       done;
        logic [1:0] ver;
        logic [1:0] layer;
        logic [3:0] bri;
        logic [1:0] sri;
        logic       pad;
    } item_t;

    typedef logic [KBPS_W-1:0] kbps_row_t [16];

    localparam kbps_row_t KBPS_LSF_L23 = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam kbps_row_t KBPS_LSF_L1 = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam kbps_row_t KBPS_V1_L3 = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam kbps_row_t KBPS_V1_L2 = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam kbps_row_t KBPS_V1_L1 = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};

    function automatic logic [KBPS_W-1:0] kbps_lookup(logic [1:0] ver, logic [1:0] layer,
                                                      logic [3:0] bri);
        logic [KBPS_W-1:0] k;
        k = '0;
        case (ver)
            VER_25, VER_2: begin
                case (layer)
                    LAYER_3, LAYER_2: k = KBPS_LSF_L23[bri];
                    LAYER_1:          k = KBPS_LSF_L1[bri];
                    default:          k = '0;
                endcase
            end
            VER_1: begin
                case (layer)
                    LAYER_3: k = KBPS_V1_L3[bri];
                    LAYER_2: k = KBPS_V1_L2[bri];
                    LAYER_1: k = KBPS_V1_L1[bri];
                    default: k = '0;
                endcase
            end
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [RATE_W-1:0] rate_lookup(logic [1:0] ver, logic [1:0] sri);
        logic [RATE_W-1:0] r;
        r = '0;
        case (ver)
            VER_25: begin
                case (sri)
                    SRI_0:   r = 16'd11025;
                    SRI_1:   r = 16'd12000;
                    SRI_2:   r = 16'd8000;
                    default: r = '0;
                endcase
            end
            VER_2: begin
                case (sri)
                    SRI_0:   r = 16'd22050;
                    SRI_1:   r = 16'd24000;
                    SRI_2:   r = 16'd16000;
                    default: r = '0;
                endcase
            end
            VER_1: begin
                case (sri)
                    SRI_0:   r = 16'd44100;
                    SRI_1:   r = 16'd48000;
                    SRI_2:   r = 16'd32000;
                    default: r = '0;
                endcase
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [SAMP_W-1:0] samples_lookup(logic [1:0] ver, logic [1:0] layer);
        logic [SAMP_W-1:0] s;
        s = '0;
        if (ver != VER_RES) begin
            case (layer)
                LAYER_3: s = (ver == VER_1) ? 11'd1152 : 11'd576;
                LAYER_2: s = 11'd1152;
                LAYER_1: s = 11'd384;
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    // samples * 1000 / 8, exact for every table entry
    function automatic logic [SCALED_W-1:0] scaled_lookup(logic [1:0] ver, logic [1:0] layer);
        logic [SCALED_W-1:0] s;
        s = '0;
        case (samples_lookup(ver, layer))
            11'd384:  s = 18'd48000;
            11'd576:  s = 18'd72000;
            11'd1152: s = 18'd144000;
            default:  s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] slot_lookup(logic [1:0] layer);
        logic [2:0] s;
        case (layer)
            LAYER_1:          s = 3'd4;
            LAYER_2, LAYER_3: s = 3'd1;
            default:          s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/mahp_front.sv
// front end: header position tracking and byte classification
module mahp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            restart,
    output mahp_pkg::item_t item
);
    import mahp_pkg::*;

    typedef enum logic [3:0] {
        POS_SYNC = 4'b0001,
        POS_VL   = 4'b0010,
        POS_RP   = 4'b0100,
        POS_LAST = 4'b1000
    } pos_t;

    pos_t       pos_reg, pos_next, pos_cur;
    logic [7:0] vl_reg, vl_next;
    logic [7:0] rp_reg, rp_next;
    logic       done;

    always_comb begin
        pos_cur  = restart ? POS_SYNC : pos_reg;
        vl_next  = (pos_cur == POS_VL) ? data_byte : vl_reg;
        rp_next  = (pos_cur == POS_RP) ? data_byte : rp_reg;
        done     = 1'b0;
        pos_next = POS_SYNC;
        if (data_byte == SYNC_BYTE) begin
            pos_next = POS_VL;
        end else begin
            case (pos_cur)
                POS_SYNC: pos_next = POS_SYNC;
                POS_VL: begin
                    if (data_byte[7:5] != SYNC_BITS || vl_next[4:3] == VER_RES ||
                        vl_next[2:1] == LAYER_RES) begin
                        pos_next = POS_SYNC;
                    end else begin
                        pos_next = POS_RP;
                    end
                end
                POS_RP: begin
                    if (rp_next[7:4] == BRI_BAD || rp_next[3:2] == SRI_RES) begin
                        pos_next = POS_SYNC;
                    end else begin
                        pos_next = POS_LAST;
                    end
                end
                POS_LAST: begin
                    pos_next = POS_SYNC;
                    done     = 1'b1;
                end
                default: pos_next = POS_SYNC;
            endcase
        end
    end

    assign item.done  = done;
    assign item.ver   = vl_next[4:3];
    assign item.layer = vl_next[2:1];
    assign item.bri   = rp_next[7:4];
    assign item.sri   = rp_next[3:2];
    assign item.pad   = rp_next[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_SYNC;
            vl_reg  <= '0;
            rp_reg  <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
            vl_reg  <= vl_next;
            rp_reg  <= rp_next;
        end
    end

endmodule

FILE: hdl/mahp_queue.sv
// small register queue between the front and back ends
module mahp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mahp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mahp_pkg::item_t pop_item
);
    import mahp_pkg::*;

    item_t               slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/mahp_back.sv
// back end: frame length multiply and bit-serial divide, result register
module mahp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  mahp_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_header_done,
    output logic [mahp_pkg::LEN_W-1:0]    m_frame_length,
    output logic [mahp_pkg::RATE_W-1:0]   m_sample_rate_hz,
    output logic [mahp_pkg::SAMP_W-1:0]   m_samples_per_frame
);
    import mahp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic [LEN_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [SAMP_W-1:0]   samp_reg, samp_next;

    logic [RATE_W-1:0]   rate_w;
    logic [PROD_W-1:0]   prod_w;
    logic [RATE_W:0]     trial_w;
    logic                ge_w;
    logic [LEN_W-1:0]    slot_w;

    assign rate_w  = rate_lookup(item_reg.ver, item_reg.sri);
    assign prod_w  = PROD_W'(scaled_lookup(item_reg.ver, item_reg.layer)) *
                     PROD_W'(kbps_lookup(item_reg.ver, item_reg.layer, item_reg.bri));
    assign trial_w = {rem_reg, lo_reg[LEN_W-1]};
    assign ge_w    = (trial_w >= {1'b0, rate_w});
    assign slot_w  = item_reg.pad ? LEN_W'(slot_lookup(item_reg.layer)) : '0;

    assign q_pop               = (state_reg == ST_IDLE) && q_not_empty;
    assign m_valid             = (state_reg == ST_OUT);
    assign m_header_done       = done_reg;
    assign m_frame_length      = len_reg;
    assign m_sample_rate_hz    = rate_reg;
    assign m_samples_per_frame = samp_reg;

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        len_next   = len_reg;
        rate_next  = rate_reg;
        samp_next  = samp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    item_next = q_item;
                    rate_next = rate_lookup(q_item.ver, q_item.sri);
                    samp_next = samples_lookup(q_item.ver, q_item.layer);
                    done_next = q_item.done;
                    len_next  = '0;
                    state_next = q_item.done ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                // numerator is below rate * 2^12, so the top part starts below rate
                if (rate_w == '0) begin
                    len_next   = slot_w;
                    state_next = ST_OUT;
                end else begin
                    rem_next   = RATE_W'(prod_w[PROD_W-1:LEN_W]);
                    lo_next    = prod_w[LEN_W-1:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = ge_w ? RATE_W'(trial_w - {1'b0, rate_w}) : trial_w[RATE_W-1:0];
                lo_next  = {lo_reg[LEN_W-2:0], ge_w};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    len_next   = lo_next + slot_w;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        cnt_reg  <= cnt_next;
        done_reg <= done_next;
        len_reg  <= len_next;
        rate_reg <= rate_next;
        samp_reg <= samp_next;
    end

endmodule

FILE: hdl/mpeg_audio_frame_header_parser.sv
// top level of the mpeg audio frame header parser
//
// input channel: one stream byte per request on s_data_byte, s_restart drops
// any partly seen header before the byte is looked at
// result channel: exactly one result request per input byte, in input order,
// carrying header_done, frame_length, sample_rate_hz and samples_per_frame
// path: a byte that does not end a header passes through the queue into the
// back end and is offered on the result channel; the fourth header byte also
// passes the multiplier and the one-bit-per-cycle divider first, and time
// spent queued behind earlier bytes adds on; the back end takes one byte at
// a time and pops the next only once the result is taken, while the front
// keeps taking bytes into a four-deep queue
// reset: header position and stored header bytes clear, queue and result
// register empty, no result request pending
// when the receiver stalls the result holds steady, the back end waits, and
// the front fills the queue; s_ready drops only when the queue is full
module mpeg_audio_frame_header_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_header_done,
    output logic [mahp_pkg::LEN_W-1:0]    m_frame_length,
    output logic [mahp_pkg::RATE_W-1:0]   m_sample_rate_hz,
    output logic [mahp_pkg::SAMP_W-1:0]   m_samples_per_frame
);
    import mahp_pkg::*;

    logic  accept;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    item_t front_item;
    item_t q_item;

    // take a byte whenever the queue has room
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // position tracking and header checks, one byte per cycle while the queue has room
    mahp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .restart   (s_restart),
        .item      (front_item)
    );

    // decouples byte intake from the slow length computation
    mahp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    // table lookups, multiply, serial divide and the result register
    mahp_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_not_empty         (q_not_empty),
        .q_item              (q_item),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_header_done       (m_header_done),
        .m_frame_length      (m_frame_length),
        .m_sample_rate_hz    (m_sample_rate_hz),
        .m_samples_per_frame (m_samples_per_frame)
    );

endmodule

FILE: hdl/mahp_checker.sv
// port-level checks of the header parser, bound to the top level
`include "assert_macros.svh"

module mahp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_header_done,
    input logic [mahp_pkg::LEN_W-1:0]    m_frame_length,
    input logic [mahp_pkg::RATE_W-1:0]   m_sample_rate_hz,
    input logic [mahp_pkg::SAMP_W-1:0]   m_samples_per_frame
);
    import mahp_pkg::*;

    logic                                  stall;
    logic [LEN_W+RATE_W+SAMP_W:0]          held;
    logic                                  tables_ok;

    assign stall     = m_valid && !m_ready;
    assign held      = {m_header_done, m_frame_length, m_sample_rate_hz, m_samples_per_frame};
    assign tables_ok = (m_sample_rate_hz != '0) && (m_samples_per_frame != '0);

    // a stalled result keeps its contents
    `MAHP_ASSERT(a_hold, stall |=> m_valid && $stable(held), "result changed while stalled")

    // no length unless a header completed
    `MAHP_ASSERT(a_len_zero, m_valid && !m_header_done |-> m_frame_length == '0, "stray length")

    // a completed header always has a real rate and sample count
    `MAHP_ASSERT(a_done_tables, m_valid && m_header_done |-> tables_ok, "reserved codes in header")

    // reset leaves no result pending
    `MAHP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result pending after reset")

endmodule

bind mpeg_audio_frame_header_parser mahp_checker u_checker (.*);
